>>> rtl/lpp_pkg.sv
package lpp_pkg;

    localparam int MaxImageWidth  = 4096;
    localparam int MaxImageHeight = 4096;

    localparam int CoefW = 16;
    localparam int PointW = 24;
    // R*p: 16x24 products, three summed plus translation, fits in 43 bits.
    localparam int CamW = 43;
    // K*cam: 16x43 products summed, magnitudes below 2^60.
    localparam int ProjW = 62;
    localparam int QuotW = 14;
    localparam int CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        REG_EXT_X  = 3'd0,
        REG_EXT_Y  = 3'd1,
        REG_EXT_Z  = 3'd2,
        REG_INT_U  = 3'd3,
        REG_INT_V  = 3'd4,
        REG_INT_W  = 3'd5,
        REG_WIDTH  = 3'd6,
        REG_HEIGHT = 3'd7
    } cfg_reg_t;

    // Color lookup: c = floor(d * 255 / 40) for d in 0..40.
    // The ratio 255 / 40 reduces to 51 / 8, so a shift does the division.
    function automatic logic [7:0] depth_color(input logic [5:0] d);
        logic [11:0] prod;
        prod = 12'(d) * 12'd51;
        return prod[10:3];
    endfunction

    typedef struct packed {
        logic [QuotW-1:0] col;
        logic [QuotW-1:0] row;
        logic [7:0]       c;
    } lpp_item_t;

endpackage

>>> rtl/lidar_point_projector_top.sv
// An accepted point passes the front stages, the divider and the result queue.
// Throughput: one point per cycle while in_stall is low; the input stalls
// when the result queue nears full, so an output stall throttles the input.
// Reset is asynchronous and active low: it empties the pipeline and queue
// and loads identity transforms and a 1920 x 1080 image.
module lidar_point_projector_top #(
    parameter int MAX_IMAGE_WIDTH  = lpp_pkg::MaxImageWidth,
    parameter int MAX_IMAGE_HEIGHT = lpp_pkg::MaxImageHeight
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] point_x,
    input  logic signed [23:0] point_y,
    input  logic signed [23:0] point_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [11:0]        pixel_col,
    output logic [11:0]        pixel_row,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import lpp_pkg::*;

    logic [63:0] ext_x_reg, ext_y_reg, ext_z_reg;
    logic [47:0] int_u_reg, int_v_reg, int_w_reg;
    logic [12:0] img_w_reg, img_h_reg;

    logic             prj_valid, prj_keep, div_valid, q_full;
    logic [ProjW-1:0] prj_u, prj_v, prj_w;
    logic [5:0]       prj_depth;
    lpp_item_t        div_item;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_x_reg <= 64'd4096;
            ext_y_reg <= 64'd268435456;
            ext_z_reg <= 64'd17592186044416;
            int_u_reg <= 48'd4;
            int_v_reg <= 48'd262144;
            int_w_reg <= 48'd17179869184;
            img_w_reg <= 13'd1920;
            img_h_reg <= 13'd1080;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_EXT_X:  ext_x_reg <= cfg_data;
                REG_EXT_Y:  ext_y_reg <= cfg_data;
                REG_EXT_Z:  ext_z_reg <= cfg_data;
                REG_INT_U:  int_u_reg <= cfg_data[47:0];
                REG_INT_V:  int_v_reg <= cfg_data[47:0];
                REG_INT_W:  int_w_reg <= cfg_data[47:0];
                REG_WIDTH:  img_w_reg <= cfg_data[12:0];
                REG_HEIGHT: img_h_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    lpp_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .stall_in(q_full),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .ext_x(ext_x_reg), .ext_y(ext_y_reg), .ext_z(ext_z_reg),
        .int_u(int_u_reg), .int_v(int_v_reg), .int_w(int_w_reg),
        .prj_valid(prj_valid), .prj_keep(prj_keep),
        .prj_u(prj_u), .prj_v(prj_v), .prj_w(prj_w), .prj_depth(prj_depth)
    );

    lpp_divider u_div (
        .clk(clk), .rst_n(rst_n), .stall_in(q_full),
        .in_valid(prj_valid), .in_keep(prj_keep),
        .u(prj_u), .v(prj_v), .w(prj_w), .depth(prj_depth),
        .out_valid(div_valid), .out_item(div_item)
    );

    lpp_back #(
        .MAX_IMAGE_WIDTH(MAX_IMAGE_WIDTH), .MAX_IMAGE_HEIGHT(MAX_IMAGE_HEIGHT)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .item_valid(div_valid), .item(div_item),
        .img_w(img_w_reg), .img_h(img_h_reg), .q_full(q_full),
        .out_valid(out_valid), .out_stall(out_stall),
        .pixel_col(pixel_col), .pixel_row(pixel_row),
        .red(red), .green(green), .blue(blue)
    );

endmodule

>>> rtl/lpp_front.sv
module lpp_front (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic                                      stall_in,
    input  logic signed [lpp_pkg::PointW-1:0]         point_x,
    input  logic signed [lpp_pkg::PointW-1:0]         point_y,
    input  logic signed [lpp_pkg::PointW-1:0]         point_z,
    input  logic [63:0]                               ext_x,
    input  logic [63:0]                               ext_y,
    input  logic [63:0]                               ext_z,
    input  logic [47:0]                               int_u,
    input  logic [47:0]                               int_v,
    input  logic [47:0]                               int_w,
    output logic                                      prj_valid,
    output logic                                      prj_keep,
    output logic [lpp_pkg::ProjW-1:0]                 prj_u,
    output logic [lpp_pkg::ProjW-1:0]                 prj_v,
    output logic [lpp_pkg::ProjW-1:0]                 prj_w,
    output logic [5:0]                                prj_depth
);
    import lpp_pkg::*;

    // Two stages: extrinsic transform, then intrinsic projection with the
    // sign checks. Each stage advances whenever the downstream is not stalled.
    logic                   s1_valid_reg, s1_valid_next;
    logic signed [CamW-1:0] cx_reg, cy_reg, cz_reg;
    logic                   s2_valid_reg;
    logic                   keep_reg;
    logic signed [ProjW-1:0] u_reg, v_reg, w_reg;
    logic [5:0]             depth_reg;

    function automatic logic signed [CamW-1:0] ext_row(
        input logic [63:0] r,
        input logic signed [PointW-1:0] x,
        input logic signed [PointW-1:0] y,
        input logic signed [PointW-1:0] z);
        logic signed [CamW-1:0] acc;
        acc = CamW'($signed(r[15:0]) * x) + CamW'($signed(r[31:16]) * y)
            + CamW'($signed(r[47:32]) * z)
            + (CamW'($signed(r[63:48])) <<< 8);
        return acc;
    endfunction

    function automatic logic signed [ProjW-1:0] int_row(
        input logic [47:0] r,
        input logic signed [CamW-1:0] a,
        input logic signed [CamW-1:0] b,
        input logic signed [CamW-1:0] c);
        logic signed [ProjW-1:0] acc;
        acc = ProjW'($signed(r[15:0]) * a) + ProjW'($signed(r[31:16]) * b)
            + ProjW'($signed(r[47:32]) * c);
        return acc;
    endfunction

    logic signed [ProjW-1:0] u_c, v_c, w_c;
    logic signed [CamW-1:0]  dm_c;
    logic [5:0]              dclamp_c;

    assign s1_valid_next = in_valid;
    assign u_c = int_row(int_u, cx_reg, cy_reg, cz_reg);
    assign v_c = int_row(int_v, cx_reg, cy_reg, cz_reg);
    assign w_c = int_row(int_w, cx_reg, cy_reg, cz_reg);
    assign dm_c = (cz_reg >>> 20) - CamW'(5);

    always_comb
    begin
        if (dm_c < 0)
            dclamp_c = 6'd0;
        else if (dm_c > CamW'(40))
            dclamp_c = 6'd40;
        else
            dclamp_c = dm_c[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (!stall_in)
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_in)
        begin
            cx_reg    <= ext_row(ext_x, point_x, point_y, point_z);
            cy_reg    <= ext_row(ext_y, point_x, point_y, point_z);
            cz_reg    <= ext_row(ext_z, point_x, point_y, point_z);
            u_reg     <= u_c;
            v_reg     <= v_c;
            w_reg     <= w_c;
            depth_reg <= dclamp_c;
            keep_reg  <= (cz_reg > 0) && (w_c > 0) && (u_c >= 0) && (v_c >= 0);
        end
    end

    assign prj_valid = s2_valid_reg;
    assign prj_keep  = keep_reg;
    assign prj_u     = u_reg;
    assign prj_v     = v_reg;
    assign prj_w     = w_reg;
    assign prj_depth = depth_reg;

endmodule

>>> rtl/lpp_divider.sv
module lpp_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              stall_in,
    input  logic                              in_valid,
    input  logic                              in_keep,
    input  logic [lpp_pkg::ProjW-1:0]         u,
    input  logic [lpp_pkg::ProjW-1:0]         v,
    input  logic [lpp_pkg::ProjW-1:0]         w,
    input  logic [5:0]                        depth,
    output logic                              out_valid,
    output lpp_pkg::lpp_item_t                out_item
);
    import lpp_pkg::*;

    // Restoring division pipeline, one quotient bit per stage. Quotients
    // are saturated to QuotW bits: anything at or above 2^(QuotW-1) lies
    // outside every legal image, so only that flag is carried.
    localparam int Stages = QuotW;
    localparam int RemW = ProjW + 1;

    logic             vld_reg  [Stages+1];
    logic             keep_reg [Stages+1];
    logic [ProjW-1:0] w_reg    [Stages+1];
    logic [RemW-1:0]  ru_reg   [Stages+1];
    logic [RemW-1:0]  rv_reg   [Stages+1];
    logic [QuotW-1:0] qu_reg   [Stages+1];
    logic [QuotW-1:0] qv_reg   [Stages+1];
    logic             ovu_reg  [Stages+1];
    logic             ovv_reg  [Stages+1];
    logic [5:0]       d_reg    [Stages+1];

    // High-bit overflow check: if u >= w * 2^(QuotW-1) the column is huge.
    logic [ProjW+QuotW-1:0] wsh_c;
    assign wsh_c = (ProjW+QuotW)'(w) << (QuotW - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= Stages; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (!stall_in)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= Stages; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall_in)
        begin
            keep_reg[0] <= in_keep;
            w_reg[0]    <= w;
            ru_reg[0]   <= RemW'(u);
            rv_reg[0]   <= RemW'(v);
            qu_reg[0]   <= '0;
            qv_reg[0]   <= '0;
            ovu_reg[0]  <= (ProjW+QuotW)'(u) >= wsh_c;
            ovv_reg[0]  <= (ProjW+QuotW)'(v) >= wsh_c;
            d_reg[0]    <= depth;
            for (int i = 1; i <= Stages; i++)
            begin
                logic [ProjW+QuotW-1:0] ws;
                logic                   gu, gv;
                ws = (ProjW+QuotW)'(w_reg[i-1]) << (Stages - i);
                gu = (ProjW+QuotW)'(ru_reg[i-1]) >= ws;
                gv = (ProjW+QuotW)'(rv_reg[i-1]) >= ws;
                keep_reg[i] <= keep_reg[i-1];
                w_reg[i]    <= w_reg[i-1];
                ovu_reg[i]  <= ovu_reg[i-1];
                ovv_reg[i]  <= ovv_reg[i-1];
                d_reg[i]    <= d_reg[i-1];
                ru_reg[i]   <= gu ? RemW'((ProjW+QuotW)'(ru_reg[i-1]) - ws) : ru_reg[i-1];
                rv_reg[i]   <= gv ? RemW'((ProjW+QuotW)'(rv_reg[i-1]) - ws) : rv_reg[i-1];
                qu_reg[i]   <= qu_reg[i-1] | (QuotW'(gu) << (Stages - i));
                qv_reg[i]   <= qv_reg[i-1] | (QuotW'(gv) << (Stages - i));
            end
        end
    end

    // Overflowed quotients saturate to the top value, which is outside
    // every image since limits stay below 2^(QuotW-1).
    assign out_valid    = vld_reg[Stages] && keep_reg[Stages];
    assign out_item.col = ovu_reg[Stages] ? '1 : qu_reg[Stages];
    assign out_item.row = ovv_reg[Stages] ? '1 : qv_reg[Stages];
    assign out_item.c   = depth_color(d_reg[Stages]);

endmodule

>>> rtl/lpp_back.sv
module lpp_back #(
    parameter int MAX_IMAGE_WIDTH  = lpp_pkg::MaxImageWidth,
    parameter int MAX_IMAGE_HEIGHT = lpp_pkg::MaxImageHeight
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  lpp_pkg::lpp_item_t   item,
    input  logic [12:0]          img_w,
    input  logic [12:0]          img_h,
    output logic                 q_full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [11:0]          pixel_col,
    output logic [11:0]          pixel_row,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue
);
    import lpp_pkg::*;

    localparam int Depth = 4;
    localparam int PtrW = 2;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  c;
    } res_t;

    // The queue holds finished beats while the output stalls:
    // the upstream freezes once q_full rises and nothing else enters.
    res_t             mem_reg [Depth];
    logic [PtrW-1:0]  wp_reg, rp_reg;
    logic [PtrW:0]    cnt_reg, cnt_next;

    logic [13:0] wmax_c, hmax_c;
    logic        in_img_c, push_c, pop_c;
    res_t        head_c;

    assign wmax_c = (14'(img_w) < 14'(MAX_IMAGE_WIDTH)) ? 14'(img_w) : 14'(MAX_IMAGE_WIDTH);
    assign hmax_c = (14'(img_h) < 14'(MAX_IMAGE_HEIGHT)) ? 14'(img_h) : 14'(MAX_IMAGE_HEIGHT);
    assign in_img_c = (item.col < wmax_c) && (item.row < hmax_c);
    assign push_c = item_valid && in_img_c && !q_full;
    assign pop_c  = (cnt_reg != '0) && !out_stall;
    assign cnt_next = cnt_reg + (PtrW+1)'(push_c) - (PtrW+1)'(pop_c);
    assign q_full = cnt_reg >= (PtrW+1)'(Depth - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push_c)
                wp_reg <= wp_reg + 1'b1;
            if (pop_c)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_c)
            mem_reg[wp_reg] <= '{col: item.col[11:0], row: item.row[11:0], c: item.c};
    end

    assign head_c    = mem_reg[rp_reg];
    assign out_valid = cnt_reg != '0;
    assign pixel_col = head_c.col;
    assign pixel_row = head_c.row;
    assign green     = head_c.c;
    assign blue      = 8'd255 - head_c.c;
    assign red       = head_c.c[7] ? 8'((8'd255 - head_c.c) << 1) : 8'(head_c.c << 1);

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PtrW+1)'(Depth))
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push_c)
        else $error("push into full queue");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_c && !push_c) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("pop did not drop count");

endmodule
